FILE: rtl/bdne_pkg.sv
// Package for the button debounce / note event block.
// Holds the item, per-button state and control structs, plus fixed constants.
// No dependencies.
package bdne_pkg;

  // Debounce history patterns that count as a settled level
  localparam logic [7:0] HistForce = 8'h80;
  localparam logic [7:0] HistFull  = 8'hFF;

  // Register index of the MIDI channel register on the configuration port
  localparam logic RegIdxMidiChannel = 1'b0;

  typedef struct packed {
    logic [5:0] button_id;
    logic       sample;
    logic       debounce_on;
    logic [6:0] note_number;
    logic       latching_mode;
    logic       program_change;
    logic       led_local;
  } bdne_item_t;

  typedef struct packed {
    logic [7:0] hist;
    logic       pressed;
    logic       last;
  } bdne_state_t;

  localparam int unsigned StateW = $bits(bdne_state_t);

  typedef struct packed {
    logic emit;
    logic note_on;
  } bdne_ctl_t;

endpackage

FILE: rtl/bdne_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module bdne_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bdne_eval.sv
// Per-sample debounce and note event decision for one button.
// Depends on bdne_pkg for the item, state and control types.
module bdne_eval import bdne_pkg::*; (
  input  bdne_item_t  item_i,
  input  bdne_state_t state_i,
  output bdne_state_t state_o,
  output bdne_ctl_t   ctl_o
);

  logic [7:0] hist_new;
  logic       settled;
  logic       momentary;

  // shift left, OR in the sample, force the top bit
  assign hist_new  = {1'b1, state_i.hist[5:0], item_i.sample};
  assign settled   = !item_i.debounce_on || (hist_new == HistForce) || (hist_new == HistFull);
  assign momentary = item_i.program_change || !item_i.latching_mode;

  always_comb begin
    state_o       = state_i;
    ctl_o.emit    = 1'b0;
    ctl_o.note_on = 1'b0;
    if (item_i.debounce_on) begin
      state_o.hist = hist_new;
    end
    if (settled) begin
      state_o.last = item_i.sample;
      if (momentary) begin
        if (item_i.sample && !state_i.pressed) begin
          state_o.pressed = 1'b1;
          ctl_o.emit      = 1'b1;
          ctl_o.note_on   = 1'b1;
        end else if (!item_i.sample && state_i.pressed) begin
          // program change: drop the release message
          state_o.pressed = 1'b0;
          ctl_o.emit      = !item_i.program_change;
        end
      end else if (item_i.sample && !state_i.last) begin
        state_o.pressed = !state_i.pressed;
        ctl_o.emit      = 1'b1;
        ctl_o.note_on   = !state_i.pressed;
      end
    end
  end

endmodule

FILE: rtl/button_debounce_note_events.sv
// Top level of the button debounce and note event block.
// Depends on bdne_pkg, bdne_ram (per-button state store) and bdne_eval (decision logic).
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------------
//  input    | in_valid_i / in_stall_o   | button_id_i .. led_local_i (one sample)
//  output   | out_valid_o / out_stall_i | event_button_o .. led_update_o (one event)
//  config   | APB psel/penable/pready   | paddr 0: midi_channel[3:0]
//
// One transaction per cycle sustained unless a blocked event stalls the input; after acceptance,
// a sample's RAM read runs alongside the input register, then its decision goes into the output register.
// The per-button state RAM has one write and one read port; the last write is
// forwarded so back-to-back samples for the same button see fresh state.
// Reset clears the channel register and a valid bit per button; an unwritten
// entry reads as zero, so no clearing pass is needed.
// A stalled output holds its event; the input stalls only when a waiting sample
// has an event to pass and the output register cannot take it.
module button_debounce_note_events import bdne_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input transactions
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [5:0]  button_id_i,
  input  logic        sample_i,
  input  logic        debounce_on_i,
  input  logic [6:0]  note_number_i,
  input  logic        latching_mode_i,
  input  logic        program_change_i,
  input  logic        led_local_i,
  // output transactions
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  event_button_o,
  output logic [6:0]  event_note_o,
  output logic        note_on_o,
  output logic [3:0]  event_channel_o,
  output logic        led_update_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  // ---------------------------------------------------------------- config
  logic [3:0] midi_channel_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegIdxMidiChannel);
  assign prdata = (paddr[2] == RegIdxMidiChannel) ? {28'd0, midi_channel_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      midi_channel_q <= 4'd0;
    end else if (cfg_wr) begin
      midi_channel_q <= pwdata[3:0];
    end
  end

  // ---------------------------------------------------------------- stage 1
  bdne_item_t             in_item;
  bdne_item_t             s1_q;
  logic                   s1_valid_q;
  logic                   in_acc;
  logic                   s1_adv;
  logic                   s1_in_range;
  logic                   s1_emit;
  logic [IdxW-1:0]        in_idx;
  logic [IdxW-1:0]        s1_idx;
  logic [StateW-1:0]      ram_rdata;
  bdne_state_t            state_cur;
  bdne_state_t            state_new;
  bdne_ctl_t              ctl;
  logic                   wr_en;
  logic [NUM_BUTTONS-1:0] entry_valid_q;
  logic                   fwd_valid_q;
  logic [IdxW-1:0]        fwd_addr_q;
  bdne_state_t            fwd_data_q;
  logic                   fwd_hit;

  assign in_item = '{
    button_id:      button_id_i,
    sample:         sample_i,
    debounce_on:    debounce_on_i,
    note_number:    note_number_i,
    latching_mode:  latching_mode_i,
    program_change: program_change_i,
    led_local:      led_local_i
  };

  assign in_idx      = IdxW'(button_id_i);
  assign s1_idx      = IdxW'(s1_q.button_id);
  assign s1_in_range = {3'b000, s1_q.button_id} < 9'(NUM_BUTTONS);

  // Pick the freshest copy: last write, else RAM if ever written, else reset value
  assign fwd_hit = fwd_valid_q && (fwd_addr_q == s1_idx);
  always_comb begin
    priority if (fwd_hit) begin
      state_cur = fwd_data_q;
    end else if (entry_valid_q[s1_idx]) begin
      state_cur = bdne_state_t'(ram_rdata);
    end else begin
      state_cur = '0;
    end
  end

  bdne_eval u_eval (
    .item_i  (s1_q),
    .state_i (state_cur),
    .state_o (state_new),
    .ctl_o   (ctl)
  );

  assign s1_emit    = s1_valid_q && s1_in_range && ctl.emit;
  assign s1_adv     = s1_valid_q && (!s1_emit || !out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  // out-of-range buttons touch no state
  assign wr_en      = s1_adv && s1_in_range;

  bdne_ram #(
    .Width (StateW),
    .Depth (NUM_BUTTONS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_idx),
    .wdata_i (state_new),
    .re_i    (in_acc),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      entry_valid_q <= '0;
      fwd_valid_q   <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (wr_en) begin
        entry_valid_q[s1_idx] <= 1'b1;
        fwd_valid_q           <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_item;
    end
    if (wr_en) begin
      fwd_addr_q <= s1_idx;
      fwd_data_q <= state_new;
    end
  end

  // ---------------------------------------------------------------- output
  logic       out_valid_q;
  logic       out_load;
  logic [5:0] ev_button_q;
  logic [6:0] ev_note_q;
  logic       ev_on_q;
  logic [3:0] ev_channel_q;
  logic       ev_led_q;

  assign out_load = s1_adv && s1_emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ev_button_q  <= s1_q.button_id;
      ev_note_q    <= s1_q.note_number;
      ev_on_q      <= ctl.note_on;
      ev_channel_q <= midi_channel_q;
      ev_led_q     <= s1_q.led_local;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_button_o  = ev_button_q;
  assign event_note_o    = ev_note_q;
  assign note_on_o       = ev_on_q;
  assign event_channel_o = ev_channel_q;
  assign led_update_o    = ev_led_q;

  // ---------------------------------------------------------------- checks
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_emit && out_valid_o))
    else $error("input stalled without a blocked event");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (s1_valid_q && s1_in_range))
    else $error("state write for an invalid or out-of-range item");

  a_fwd_tracks_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (fwd_valid_q && (fwd_addr_q == $past(s1_idx))))
    else $error("forwarding register lost the last write");

  a_event_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("event dropped on its way to the output register");

  a_pc_no_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && s1_q.program_change) |-> ctl.note_on)
    else $error("program-change button sent a release event");

endmodule

FILE: bench/bdne_event_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the button debounce / note event block: watches both channels
// and the APB port, predicts each note event and compares it field by field.
// Depends on bdne_pkg for the item struct and the settled-history patterns.
module bdne_event_checker import bdne_pkg::*; #(
  parameter logic [2:0] CHANNEL_ADDR = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  bdne_item_t  button_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [5:0]  event_button_i,
  input  logic [6:0]  event_note_i,
  input  logic        note_on_i,
  input  logic [3:0]  event_channel_i,
  input  logic        led_update_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned sample_count_o,
  output int unsigned event_count_o
);

  typedef enum logic [1:0] {
    ModeMomentary,
    ModeLatching,
    ModeProgram
  } button_mode_e;

  typedef struct packed {
    logic [5:0] button;
    logic [6:0] note;
    logic       on;
    logic [3:0] channel;
    logic       led;
  } note_event_t;

  logic [7:0]  hist_q       [64];
  logic        pressed_q    [64];
  logic        last_level_q [64];
  logic [3:0]  channel_q;
  note_event_t pending_events [$];

  // Shift the sample into the button's history, then run the mode logic on a settled level
  task automatic debounce_and_decode(input bdne_item_t it);
    logic [7:0]   h;
    button_mode_e mode;
    logic         fire;
    logic         on;
    int unsigned  b;
    b    = it.button_id;
    fire = 1'b0;
    on   = 1'b0;
    if (it.debounce_on) begin
      h = {hist_q[b][6:0], it.sample} | HistForce;
      hist_q[b] = h;
      if (h != HistForce && h != HistFull) return;
    end
    if (it.program_change) begin
      mode = ModeProgram;
    end else if (it.latching_mode) begin
      mode = ModeLatching;
    end else begin
      mode = ModeMomentary;
    end
    case (mode)
      ModeLatching: begin
        if (it.sample && !last_level_q[b]) begin
          pressed_q[b] = !pressed_q[b];
          fire = 1'b1;
          on   = pressed_q[b];
        end
      end
      default: begin
        if (it.sample && !pressed_q[b]) begin
          pressed_q[b] = 1'b1;
          fire = 1'b1;
          on   = 1'b1;
        end else if (!it.sample && pressed_q[b]) begin
          // program change drops the release message
          pressed_q[b] = 1'b0;
          fire = (mode == ModeMomentary);
        end
      end
    endcase
    last_level_q[b] = it.sample;
    if (fire) begin
      pending_events.push_back('{button: it.button_id, note: it.note_number, on: on,
                                 channel: channel_q, led: it.led_local});
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    note_event_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 64; i++) begin
        hist_q[i]       = '0;
        pressed_q[i]    = 1'b0;
        last_level_q[i] = 1'b0;
      end
      channel_q = '0;
      pending_events.delete();
      fail_count_o   = 0;
      pending_o      = 0;
      sample_count_o = 0;
      event_count_o  = 0;
    end else begin
      // retire the output transaction first: it always belongs to an earlier sample
      if (out_valid_i && !out_stall_i) begin
        event_count_o++;
        if (pending_events.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected event, expected none, got button %0d note %0d on %0b",
                   $time, event_button_i, event_note_i, note_on_i);
        end else begin
          want = pending_events.pop_front();
          check_field("event_button", want.button, event_button_i);
          check_field("event_note", want.note, event_note_i);
          check_field("note_on", want.on, note_on_i);
          check_field("event_channel", want.channel, event_channel_i);
          check_field("led_update", want.led, led_update_i);
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == CHANNEL_ADDR) begin
        channel_q = pwdata_i[3:0];
      end
      if (in_valid_i && !in_stall_i) begin
        sample_count_o++;
        debounce_and_decode(button_item_i);
      end
      pending_o = pending_events.size();
    end
  end

endmodule

FILE: bench/button_debounce_note_events_tb.sv
`timescale 1ns / 100ps
// Top of the button debounce / note event bench: clock, reset, sample stimulus,
// APB channel writes and the verdict. Depends on bdne_pkg, the block and bdne_event_checker.
module button_debounce_note_events_tb;
  import bdne_pkg::*;

  localparam int unsigned PoolSize     = 4;
  localparam int unsigned NumChunks    = 15;
  localparam int unsigned ChunkSamples = 95;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned CycleLimit   = 300000;
  // byte address of the channel register
  localparam logic [2:0]  ChannelAddr  = {RegIdxMidiChannel, 2'b00};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [5:0]  button_id_i;
  logic        sample_i;
  logic        debounce_on_i;
  logic [6:0]  note_number_i;
  logic        latching_mode_i;
  logic        program_change_i;
  logic        led_local_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [5:0]  event_button_o;
  logic [6:0]  event_note_o;
  logic        note_on_o;
  logic [3:0]  event_channel_o;
  logic        led_update_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned pending_events;
  int unsigned samples_seen;
  int unsigned events_seen;
  int unsigned channel_settings;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Buttons being played in the current chunk: settings, level and what is left of the run
  bdne_item_t  pool_item [PoolSize];
  int unsigned pool_run  [PoolSize];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  button_debounce_note_events dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .button_id_i     (button_id_i),
    .sample_i        (sample_i),
    .debounce_on_i   (debounce_on_i),
    .note_number_i   (note_number_i),
    .latching_mode_i (latching_mode_i),
    .program_change_i(program_change_i),
    .led_local_i     (led_local_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_button_o  (event_button_o),
    .event_note_o    (event_note_o),
    .note_on_o       (note_on_o),
    .event_channel_o (event_channel_o),
    .led_update_o    (led_update_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  bdne_event_checker #(
    .CHANNEL_ADDR(ChannelAddr)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .button_item_i  ({button_id_i, sample_i, debounce_on_i, note_number_i,
                      latching_mode_i, program_change_i, led_local_i}),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_button_i (event_button_o),
    .event_note_i   (event_note_o),
    .note_on_i      (note_on_o),
    .event_channel_i(event_channel_o),
    .led_update_i   (led_update_o),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending_events),
    .sample_count_o (samples_seen),
    .event_count_o  (events_seen)
  );

  // Receiver back-pressure: redraw the stall every cycle at the falling edge
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: abandon the run if a handshake never completes
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Timed out after %0d cycles with %0d events outstanding",
               cycle_count, pending_events);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic bdne_item_t make_sample(input int unsigned id, input bit level,
                                             input bit deb, input int unsigned note,
                                             input bit latch, input bit pc, input bit led);
    bdne_item_t it;
    it.button_id      = 6'(id);
    it.sample         = level;
    it.debounce_on    = deb;
    it.note_number    = 7'(note);
    it.latching_mode  = latch;
    it.program_change = pc;
    it.led_local      = led;
    return it;
  endfunction

  // Offer one sample transaction; starts and ends at a falling edge.
  // Idle gaps drop valid; a sample that follows directly keeps valid high.
  task automatic push_sample(input bdne_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    {button_id_i, sample_i, debounce_on_i, note_number_i,
     latching_mode_i, program_change_i, led_local_i} <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drain the block, then write the channel register through a setup and an access cycle
  task automatic set_channel(input logic [3:0] value);
    in_valid_i <= 1'b0;
    while (pending_events != 0) @(negedge clk_i);
    // samples that made no event may still be in the pipeline
    repeat (DrainCycles) @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= ChannelAddr;
    pwdata  <= {16'($urandom_range(65535)), 12'($urandom_range(4095)), value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    channel_settings++;
  endtask

  // Pick fresh settings for a pool button; called between runs this is a mode change
  task automatic reroll_settings(input int unsigned k);
    pool_item[k].debounce_on    = ($urandom_range(3) != 0);
    pool_item[k].note_number    = 7'($urandom_range(127));
    pool_item[k].latching_mode  = 1'($urandom_range(1));
    pool_item[k].program_change = ($urandom_range(3) == 0);
    pool_item[k].led_local      = 1'($urandom_range(1));
  endtask

  // Start a new run of one level; debounced runs are mostly long enough to settle
  task automatic start_run(input int unsigned k);
    if ($urandom_range(9) == 0) reroll_settings(k);
    if ($urandom_range(4) != 0) pool_item[k].sample = !pool_item[k].sample;
    if (!pool_item[k].debounce_on) begin
      pool_run[k] = $urandom_range(3, 1);
    end else if ($urandom_range(6) == 0) begin
      pool_run[k] = $urandom_range(4, 1);
    end else begin
      pool_run[k] = $urandom_range(12, 7);
    end
  endtask

  // Mostly runs from the pool, interleaved; the rest is fully random noise
  task automatic next_random_sample(output bdne_item_t it);
    int unsigned k;
    if ($urandom_range(99) < 15) begin
      it = make_sample($urandom_range(63), 1'($urandom_range(1)), 1'($urandom_range(1)),
                       $urandom_range(127), 1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
    end else begin
      k = $urandom_range(PoolSize - 1);
      if (pool_run[k] == 0) start_run(k);
      it = pool_item[k];
      pool_run[k]--;
    end
  endtask

  initial begin
    bdne_item_t it;
    logic [3:0] chan;
    // hold every input at a known value through reset
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    button_id_i      = '0;
    sample_i         = 1'b0;
    debounce_on_i    = 1'b0;
    note_number_i    = '0;
    latching_mode_i  = 1'b0;
    program_change_i = 1'b0;
    led_local_i      = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    channel_settings = 0;
    send_idle_pct    = 18;
    recv_stall_pct   = 81;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part on the highest channel
    set_channel(4'hF);
    // momentary: press, repeated press, release, repeated release
    push_sample(make_sample(63, 1, 0, 127, 0, 0, 1));
    push_sample(make_sample(63, 1, 0, 127, 0, 0, 1));
    push_sample(make_sample(63, 0, 0, 127, 0, 0, 1));
    push_sample(make_sample(63, 0, 0, 127, 0, 0, 1));
    // program change: press sends, release is silent, program change beats latching
    push_sample(make_sample(0, 1, 0, 0, 0, 1, 0));
    push_sample(make_sample(0, 0, 0, 0, 0, 1, 0));
    push_sample(make_sample(0, 1, 0, 0, 1, 1, 1));
    // latching: rising edges toggle, falling edges and held levels are silent
    push_sample(make_sample(1, 1, 0, 42, 1, 0, 1));
    push_sample(make_sample(1, 0, 0, 42, 1, 0, 1));
    push_sample(make_sample(1, 0, 0, 42, 1, 0, 1));
    push_sample(make_sample(1, 1, 0, 42, 1, 0, 1));
    push_sample(make_sample(1, 1, 0, 42, 1, 0, 1));
    push_sample(make_sample(1, 0, 0, 42, 1, 0, 1));
    push_sample(make_sample(1, 1, 0, 42, 1, 0, 1));
    // switch the latched-on button to momentary: its release turns the note off
    push_sample(make_sample(1, 0, 0, 42, 0, 0, 0));
    // debounced: settle released at once, seven presses to settle pressed, then a bounce
    push_sample(make_sample(2, 0, 1, 60, 0, 0, 1));
    repeat (7) push_sample(make_sample(2, 1, 1, 60, 0, 0, 1));
    push_sample(make_sample(2, 0, 1, 60, 0, 0, 1));

    // Random part: three idling phases, new channel and button pool every chunk
    for (int c = 0; c < NumChunks; c++) begin
      case (c / 5)
        0: begin
          send_idle_pct  = 18;
          recv_stall_pct = 81;
        end
        1: begin
          send_idle_pct  = 81;
          recv_stall_pct = 18;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      case (c % 3)
        0:       chan = 4'h0;
        1:       chan = 4'hF;
        default: chan = 4'($urandom_range(14, 1));
      endcase
      set_channel(chan);
      for (int k = 0; k < PoolSize; k++) begin
        pool_item[k].button_id = 6'($urandom_range(63));
        pool_item[k].sample    = 1'($urandom_range(1));
        reroll_settings(k);
        pool_run[k] = 0;
      end
      for (int n = 0; n < ChunkSamples; n++) begin
        next_random_sample(it);
        push_sample(it);
      end
    end

    // Drop valid, wait for the last events, then let the pipeline empty
    in_valid_i <= 1'b0;
    while (pending_events != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Covered %0d button samples across %0d channel settings, %0d note events checked",
             samples_seen, channel_settings, events_seen);
    if (fail_count == 0 && pending_events == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: button_debounce_note_events.f
rtl/bdne_pkg.sv
rtl/bdne_ram.sv
rtl/bdne_eval.sv
rtl/button_debounce_note_events.sv
bench/bdne_event_checker.sv
bench/button_debounce_note_events_tb.sv
